// ===== rtl/pced_pkg.sv =====
package pced_pkg;

    localparam int REGION_BYTES = 4096;

    localparam int KEY_LEN_W = 6;
    localparam int OFFSET_W  = 13;
    localparam int POS_W     = 12;
    localparam int VARINT_W  = 32;

    localparam int VARINT_MAX_BYTES = 5;
    localparam logic [OFFSET_W-1:0] HEADER_MIN_BYTES = 13'd3;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_CAP = 6'd63;

    // usable region never exceeds what the offset counter can hold
    localparam logic [OFFSET_W-1:0] LIM_CAP =
        (REGION_BYTES > 8191) ? 13'h1FFF : 13'(REGION_BYTES);

    typedef enum logic [1:0] {
        KIND_KEY,
        KIND_VALUE,
        KIND_END,
        KIND_ERR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_OVERRUN,
        ERR_SHARED,
        ERR_SHORT,
        ERR_CAPACITY,
        ERR_VARINT
    } err_t;

    typedef enum logic [2:0] {
        PH_SHARED,
        PH_NONSHARED,
        PH_VALLEN,
        PH_KEY,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_REPLAY,
        EM_END
    } emit_state_t;

    typedef enum logic {
        CFG_REGION_LENGTH,
        CFG_MIN_KEY_LEN
    } cfg_index_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_byte;
        logic [POS_W-1:0] position;
        err_t             error_code;
        logic             last;
    } result_t;

    // what one accepted item asks of the emitter
    typedef struct packed {
        logic                 first_valid;
        result_t              first;
        logic                 replay;
        logic [KEY_LEN_W-1:0] replay_count;
        logic                 end_pending;
    } decision_t;

    function automatic result_t make_result(kind_t kind, logic [7:0] b,
                                            logic [POS_W-1:0] pos, err_t code,
                                            logic last);
        result_t r;
        r.kind       = kind;
        r.out_byte   = b;
        r.position   = pos;
        r.error_code = code;
        r.last       = last;
        return r;
    endfunction

endpackage

// ===== rtl/pced_intf.sv =====
interface pced_entry_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_start;

    modport source (output valid, data_byte, region_start, input ready);
    modport sink   (input valid, data_byte, region_start, output ready);
endinterface

interface pced_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [11:0] position;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, kind, out_byte, position, error_code, last, input ready);
    modport sink   (input valid, kind, out_byte, position, error_code, last, output ready);
endinterface

// ===== rtl/pced_key_ram.sv =====
module pced_key_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pced_parser.sv =====
module pced_parser #(
    parameter int MAX_KEY_LEN = 32,
    parameter int AW          = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic [7:0]                      data_byte,
    input  logic                            region_start,
    input  logic [pced_pkg::OFFSET_W-1:0]   region_len,
    input  logic [pced_pkg::KEY_LEN_W-1:0]  min_key_len,
    output pced_pkg::decision_t             dec,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [7:0]                      mem_wdata
);

    import pced_pkg::*;

    logic [KEY_LEN_W-1:0] key_len_reg, key_len_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    phase_t               phase_reg, phase_next;
    logic [VARINT_W-1:0]  acc_reg, acc_next;
    logic [2:0]           vcnt_reg, vcnt_next;
    logic [VARINT_W-1:0]  shared_reg, shared_next;
    logic [VARINT_W-1:0]  key_left_reg, key_left_next;
    logic [VARINT_W-1:0]  val_left_reg, val_left_next;
    logic                 err_reg, err_next;
    logic [POS_W-1:0]     vpos_reg, vpos_next;

    // state as seen by this item, after a region start has cleared it
    logic [KEY_LEN_W-1:0] key_len_cur;
    logic [OFFSET_W-1:0]  offset_cur;
    phase_t               phase_cur;
    logic [VARINT_W-1:0]  acc_cur;
    logic [2:0]           vcnt_cur;
    logic [VARINT_W-1:0]  shared_cur;
    logic [VARINT_W-1:0]  key_left_cur;
    logic [VARINT_W-1:0]  val_left_cur;
    logic                 err_cur;
    logic [POS_W-1:0]     vpos_cur;

    logic [OFFSET_W-1:0]  lim;
    logic [OFFSET_W-1:0]  rem;
    logic [VARINT_W-1:0]  shifted;
    logic [VARINT_W-1:0]  acc_sum;
    logic [VARINT_W:0]    kv_sum;
    logic [VARINT_W:0]    total;
    logic                 write_en;

    assign lim = (region_len > LIM_CAP) ? LIM_CAP : region_len;

    always_comb
    begin
        unique case (vcnt_cur)
            3'd0:    shifted = {25'b0, data_byte[6:0]};
            3'd1:    shifted = {18'b0, data_byte[6:0], 7'b0};
            3'd2:    shifted = {11'b0, data_byte[6:0], 14'b0};
            3'd3:    shifted = {4'b0, data_byte[6:0], 21'b0};
            default: shifted = {data_byte[3:0], 28'b0};
        endcase
    end

    always_comb
    begin
        if (region_start)
        begin
            key_len_cur  = '0;
            offset_cur   = '0;
            phase_cur    = PH_SHARED;
            acc_cur      = '0;
            vcnt_cur     = '0;
            shared_cur   = '0;
            key_left_cur = '0;
            val_left_cur = '0;
            err_cur      = 1'b0;
            vpos_cur     = '0;
        end
        else
        begin
            key_len_cur  = key_len_reg;
            offset_cur   = offset_reg;
            phase_cur    = phase_reg;
            acc_cur      = acc_reg;
            vcnt_cur     = vcnt_reg;
            shared_cur   = shared_reg;
            key_left_cur = key_left_reg;
            val_left_cur = val_left_reg;
            err_cur      = err_reg;
            vpos_cur     = vpos_reg;
        end
    end

    always_comb
    begin
        key_len_next  = key_len_cur;
        offset_next   = offset_cur;
        phase_next    = phase_cur;
        acc_next      = acc_cur;
        vcnt_next     = vcnt_cur;
        shared_next   = shared_cur;
        key_left_next = key_left_cur;
        val_left_next = val_left_cur;
        err_next      = err_cur;
        vpos_next     = vpos_cur;

        dec       = '0;
        write_en  = 1'b0;
        mem_waddr = key_len_cur[AW-1:0];
        mem_wdata = data_byte;

        acc_sum = acc_cur | shifted;
        rem     = lim - (offset_cur + 1'b1);
        kv_sum  = 33'(key_left_cur) + 33'(acc_sum);
        total   = 33'(shared_cur) + 33'(key_left_cur);

        if (!err_cur)
        begin
            if (offset_cur >= lim)
            begin
                // past the region: silent at an entry boundary only
                if (!(phase_cur == PH_SHARED && vcnt_cur == 3'd0))
                begin
                    err_next        = 1'b1;
                    key_len_next    = '0;
                    dec.first_valid = 1'b1;
                    dec.first       = make_result(KIND_ERR, 8'd0, '0, ERR_OVERRUN, 1'b1);
                end
            end
            else
            begin
                offset_next = offset_cur + 1'b1;
                if (phase_cur == PH_KEY)
                begin
                    write_en        = key_len_cur < KEY_LEN_W'(MAX_KEY_LEN);
                    dec.first_valid = 1'b1;
                    dec.first       = make_result(KIND_KEY, data_byte,
                                                  POS_W'(key_len_cur), ERR_NONE, 1'b1);
                    if (key_len_cur < KEY_LEN_CAP)
                    begin
                        key_len_next = key_len_cur + 1'b1;
                    end
                    key_left_next = key_left_cur - 1'b1;
                    if (key_left_next == '0)
                    begin
                        if (val_left_cur != '0)
                        begin
                            phase_next = PH_VALUE;
                        end
                        else
                        begin
                            phase_next      = PH_SHARED;
                            dec.end_pending = 1'b1;
                            dec.first.last  = 1'b0;
                        end
                    end
                end
                else if (phase_cur == PH_VALUE)
                begin
                    dec.first_valid = 1'b1;
                    dec.first       = make_result(KIND_VALUE, data_byte, vpos_cur,
                                                  ERR_NONE, 1'b1);
                    vpos_next = vpos_cur + 1'b1;
                    if (val_left_cur != '0)
                    begin
                        val_left_next = val_left_cur - 1'b1;
                    end
                    if (val_left_next == '0)
                    begin
                        phase_next      = PH_SHARED;
                        dec.end_pending = 1'b1;
                        dec.first.last  = 1'b0;
                    end
                end
                else if (phase_cur == PH_SHARED && vcnt_cur == 3'd0 &&
                         (lim - offset_cur) < HEADER_MIN_BYTES)
                begin
                    err_next        = 1'b1;
                    key_len_next    = '0;
                    dec.first_valid = 1'b1;
                    dec.first       = make_result(KIND_ERR, 8'd0, '0, ERR_OVERRUN, 1'b1);
                end
                else if (data_byte[7])
                begin
                    acc_next  = acc_sum;
                    vcnt_next = vcnt_cur + 1'b1;
                    if (vcnt_next >= 3'(VARINT_MAX_BYTES))
                    begin
                        err_next        = 1'b1;
                        key_len_next    = '0;
                        dec.first_valid = 1'b1;
                        dec.first       = make_result(KIND_ERR, 8'd0, '0, ERR_VARINT, 1'b1);
                    end
                end
                else
                begin
                    acc_next  = '0;
                    vcnt_next = '0;
                    if (phase_cur == PH_SHARED)
                    begin
                        shared_next = acc_sum;
                        phase_next  = PH_NONSHARED;
                    end
                    else if (phase_cur == PH_NONSHARED)
                    begin
                        key_left_next = acc_sum;
                        phase_next    = PH_VALLEN;
                    end
                    else
                    begin
                        // last header byte: entry checks, in priority order
                        val_left_next   = acc_sum;
                        dec.first       = make_result(KIND_ERR, 8'd0, '0, ERR_NONE, 1'b1);
                        if (kv_sum > 33'(rem))
                        begin
                            dec.first.error_code = ERR_OVERRUN;
                        end
                        else if (shared_cur > VARINT_W'(key_len_cur))
                        begin
                            dec.first.error_code = ERR_SHARED;
                        end
                        else if (total > 33'(MAX_KEY_LEN))
                        begin
                            dec.first.error_code = ERR_CAPACITY;
                        end
                        else if (total < 33'(min_key_len))
                        begin
                            dec.first.error_code = ERR_SHORT;
                        end

                        if (dec.first.error_code != ERR_NONE)
                        begin
                            err_next        = 1'b1;
                            key_len_next    = '0;
                            dec.first_valid = 1'b1;
                        end
                        else
                        begin
                            key_len_next     = shared_cur[KEY_LEN_W-1:0];
                            vpos_next        = '0;
                            dec.replay       = shared_cur != '0;
                            dec.replay_count = shared_cur[KEY_LEN_W-1:0];
                            if (key_left_cur != '0)
                            begin
                                phase_next = PH_KEY;
                            end
                            else if (acc_sum != '0)
                            begin
                                phase_next = PH_VALUE;
                            end
                            else
                            begin
                                phase_next = PH_SHARED;
                                if (shared_cur != '0)
                                begin
                                    dec.end_pending = 1'b1;
                                end
                                else
                                begin
                                    dec.first_valid = 1'b1;
                                    dec.first = make_result(KIND_END, 8'd0, '0,
                                                            ERR_NONE, 1'b1);
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    assign mem_we = fire && write_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= '0;
            offset_reg   <= '0;
            phase_reg    <= PH_SHARED;
            acc_reg      <= '0;
            vcnt_reg     <= '0;
            shared_reg   <= '0;
            key_left_reg <= '0;
            val_left_reg <= '0;
            err_reg      <= 1'b0;
            vpos_reg     <= '0;
        end
        else if (fire)
        begin
            key_len_reg  <= key_len_next;
            offset_reg   <= offset_next;
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            vcnt_reg     <= vcnt_next;
            shared_reg   <= shared_next;
            key_left_reg <= key_left_next;
            val_left_reg <= val_left_next;
            err_reg      <= err_next;
            vpos_reg     <= vpos_next;
        end
    end

endmodule

// ===== rtl/pced_emitter.sv =====
module pced_emitter #(
    parameter int AW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  pced_pkg::decision_t dec,
    input  logic [7:0]          rd_data,
    output logic [AW-1:0]       rd_addr,
    output logic                in_ready,
    pced_result_if.source       result
);

    import pced_pkg::*;

    emit_state_t          state_reg, state_next;
    logic [KEY_LEN_W-1:0] idx_reg, idx_next;
    logic [KEY_LEN_W-1:0] cnt_reg, cnt_next;
    logic                 end_reg, end_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 out_free;
    logic                 load;
    logic                 final_byte;
    logic [KEY_LEN_W-1:0] rd_idx;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        out_next   = out_reg;
        load       = 1'b0;
        in_ready   = 1'b0;
        rd_idx     = '0;
        final_byte = idx_reg == (cnt_reg - 1'b1);

        unique case (state_reg)
            EM_IDLE:
            begin
                in_ready = out_free;
                if (fire)
                begin
                    if (dec.first_valid)
                    begin
                        load     = 1'b1;
                        out_next = dec.first;
                    end
                    if (dec.replay)
                    begin
                        // entry 0 is read in this cycle, data is there next cycle
                        state_next = EM_REPLAY;
                        idx_next   = '0;
                        cnt_next   = dec.replay_count;
                        end_next   = dec.end_pending;
                    end
                    else if (dec.end_pending)
                    begin
                        state_next = EM_END;
                    end
                end
            end
            EM_REPLAY:
            begin
                rd_idx = idx_reg;
                if (out_free)
                begin
                    load     = 1'b1;
                    out_next = make_result(KIND_KEY, rd_data, POS_W'(idx_reg), ERR_NONE,
                                           final_byte && !end_reg);
                    if (final_byte)
                    begin
                        state_next = end_reg ? EM_END : EM_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_idx   = idx_reg + 1'b1;
                    end
                end
            end
            EM_END:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    out_next   = make_result(KIND_END, 8'd0, '0, ERR_NONE, 1'b1);
                    state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    // no key writes are accepted while replaying, so reads need no forwarding
    assign rd_addr = rd_idx[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_reg.kind;
    assign result.out_byte   = out_reg.out_byte;
    assign result.position   = out_reg.position;
    assign result.error_code = out_reg.error_code;
    assign result.last       = out_reg.last;

endmodule

// ===== rtl/prefix_compressed_entry_decoder_unit.sv =====
// Prefix-compressed entry decoder.
// entry channel: one raw byte of a block's entry region per item, with
// region_start set on the first byte of each region (clears key, offset,
// parse state and any sticky error before that byte is parsed).
// result channel: key bytes, value bytes, entry-end markers and one error
// item per corrupt region; last marks the final result of an input byte.
// cfg port: region length and minimum key length, written while idle.
// A byte's direct result leaves the output register in the cycle after it.
// Throughput: one byte per cycle while each byte makes at most one result.
// A byte that closes a key or value and ends the entry adds an entry end.
// The last header byte replays the shared prefix from the previous-key
// memory, one byte per cycle on its read port while the receiver takes
// them, then an entry end when the entry has no suffix and no value.
// While the receiver stalls the output register holds; a new byte is taken
// only when the output register is empty or being drained.
// Reset empties the output register and clears the parse state; the
// previous-key memory needs no clearing since it is read only after writes.
module prefix_compressed_entry_decoder_unit #(
    parameter int MAX_KEY_LEN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  pced_pkg::cfg_index_t          cfg_index,
    input  logic [pced_pkg::OFFSET_W-1:0] cfg_data,
    pced_entry_if.sink                    entry,
    pced_result_if.source                 result
);

    import pced_pkg::*;

    localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

    logic [OFFSET_W-1:0]  region_len_reg;
    logic [KEY_LEN_W-1:0] min_key_reg;
    logic                 in_ready;
    logic                 fire;
    decision_t            dec;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [7:0]           mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_len_reg <= '0;
            min_key_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_LENGTH: region_len_reg <= cfg_data;
                CFG_MIN_KEY_LEN:   min_key_reg    <= cfg_data[KEY_LEN_W-1:0];
                default:           region_len_reg <= region_len_reg;
            endcase
        end
    end

    assign entry.ready = in_ready;
    assign fire        = entry.valid && in_ready;

    pced_parser #(
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .AW          (AW)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .data_byte    (entry.data_byte),
        .region_start (entry.region_start),
        .region_len   (region_len_reg),
        .min_key_len  (min_key_reg),
        .dec          (dec),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata)
    );

    pced_key_ram #(
        .DEPTH (MAX_KEY_LEN),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pced_emitter #(
        .AW (AW)
    ) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .dec      (dec),
        .rd_data  (mem_rdata),
        .rd_addr  (mem_raddr),
        .in_ready (in_ready),
        .result   (result)
    );

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_ERR |-> result.last)
        else $error("error item without last");

    a_key_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_KEY |-> result.position < POS_W'(MAX_KEY_LEN))
        else $error("key byte position beyond key capacity");

    a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec.first_valid |=> result.valid)
        else $error("direct result of an accepted item not presented");

endmodule
